// ----- hw/rtl/rgb_to_v210_packer_macros.svh -----
// Assertion macros shared by the checker files of the RGB to v210 packer.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef RGB_TO_V210_PACKER_MACROS_SVH
`define RGB_TO_V210_PACKER_MACROS_SVH

// Antecedent and consequent are checked at the same clock edge.
`define R2V_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("r2v_checker: implication failed");

// Consequent is checked in the cycle after the antecedent.
`define R2V_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("r2v_checker: next-cycle implication failed");

`endif

// ----- hw/rtl/r2v_pkg.sv -----
// Shared types, constants and lookup functions for the RGB to v210 packer.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps

package r2v_pkg;

	localparam int COMP_W          = 10;
	localparam int WORD_W          = 3 * COMP_W;
	localparam int CARRY_W         = 2 * COMP_W;
	localparam int FIFO_DEPTH_DEF  = 16;
	// One item in each of the two lane stages plus the one being accepted,
	// each good for at most two words.
	localparam int WORDS_IN_FLIGHT = 6;

	localparam logic REG_SOURCE_FORMAT = 1'b0;
	localparam logic REG_MATRIX_SELECT = 1'b1;

	localparam logic [1:0] FMT_ARGB  = 2'd0;
	localparam logic [1:0] FMT_BGRA  = 2'd1;
	localparam logic [1:0] FMT_RGB24 = 2'd2;
	localparam logic [1:0] FMT_BGR24 = 2'd3;

	localparam logic [1:0] MAT_FULL  = 2'd0;
	localparam logic [1:0] MAT_BT601 = 2'd1;
	localparam logic [1:0] MAT_BT709 = 2'd2;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic signed [10:0] kr;
		logic signed [10:0] kg;
		logic signed [10:0] kb;
		logic [9:0]         off;
	} coef_t;

	typedef struct packed {
		logic [COMP_W-1:0] y1;
		logic [COMP_W-1:0] cb;
		logic [COMP_W-1:0] cr;
		logic [COMP_W-1:0] y2;
	} comp_set_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} out_entry_t;

	function automatic rgb_t split_rgb(input logic [31:0] px, input logic [1:0] fmt);
		rgb_t c;
		case (fmt)
			FMT_ARGB: begin
				c.r = px[15:8];
				c.g = px[23:16];
				c.b = px[31:24];
			end
			FMT_RGB24: begin
				c.r = px[7:0];
				c.g = px[15:8];
				c.b = px[23:16];
			end
			default: begin
				// BGRA and BGR24 share the order of their first three bytes.
				c.b = px[7:0];
				c.g = px[15:8];
				c.r = px[23:16];
			end
		endcase
		return c;
	endfunction

	// The undefined preset code falls back to full range.
	function automatic coef_t y_coef(input logic [1:0] mat);
		coef_t k;
		case (mat)
			MAT_BT601: k = '{kr: 11'sd263, kg: 11'sd516, kb: 11'sd100, off: 10'd64};
			MAT_BT709: k = '{kr: 11'sd187, kg: 11'sd629, kb: 11'sd63, off: 10'd64};
			default:   k = '{kr: 11'sd306, kg: 11'sd601, kb: 11'sd117, off: 10'd0};
		endcase
		return k;
	endfunction

	function automatic coef_t cb_coef(input logic [1:0] mat);
		coef_t k;
		case (mat)
			MAT_BT601: k = '{kr: -11'sd152, kg: -11'sd298, kb: 11'sd450, off: 10'd512};
			MAT_BT709: k = '{kr: -11'sd103, kg: -11'sd347, kb: 11'sd450, off: 10'd512};
			default:   k = '{kr: -11'sd173, kg: -11'sd339, kb: 11'sd512, off: 10'd512};
		endcase
		return k;
	endfunction

	function automatic coef_t cr_coef(input logic [1:0] mat);
		coef_t k;
		case (mat)
			MAT_BT601: k = '{kr: 11'sd450, kg: -11'sd377, kb: -11'sd73, off: 10'd512};
			MAT_BT709: k = '{kr: 11'sd450, kg: -11'sd409, kb: -11'sd41, off: 10'd512};
			default:   k = '{kr: 11'sd512, kg: -11'sd429, kb: -11'sd83, off: 10'd512};
		endcase
		return k;
	endfunction

endpackage

// ----- hw/rtl/rgb_to_v210_packer.sv -----
// Top level of the RGB to 10-bit 4:2:2 v210 packer.
// Instantiates four r2v_lane conversion lanes and the r2v_pack merge stage; uses r2v_pkg.
`timescale 1ns / 1ps

// Usage:
//   Pixel channel: pixel_valid / pixel_stall carry one pixel pair per transaction
//   (first_pixel, second_pixel). Word channel: word_valid / word_stall carry one
//   v210 word (packed_word) per transaction; last marks the final word of a pair.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
//   source_format, index 1 is matrix_select. cfg_ready is always high; write only
//   while the block is idle.
// Throughput: one pixel pair per clock while the word queue has room. Three pairs
//   make four words, so when the receiver never stalls the word port, one word per
//   clock, sets the sustained rate at three pairs for every four words read.
// Path: the first word of a pair passes the two lane stages, the merge stage
//   writing the word queue and the output register before it reaches the port.
// Stall: pixel_stall rises when the word queue could no longer take every word of
//   the pairs inside the lanes; it depends only on the queue fill.
// Reset: clears phase, partial word, queue pointers and both registers; the queue
//   is empty and pixel_stall is low right after reset.

module rgb_to_v210_packer
	import r2v_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	input  logic [31:0]       first_pixel,
	input  logic [31:0]       second_pixel,
	output logic              word_valid,
	input  logic              word_stall,
	output logic [WORD_W-1:0] packed_word,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [1:0]        cfg_data
);

	logic [1:0] source_format_q;
	logic [1:0] matrix_select_q;
	logic       valid_s1;
	logic       valid_s2;
	logic       accept;
	rgb_t       pix1;
	rgb_t       pix2;
	coef_t      k_y;
	coef_t      k_cb;
	coef_t      k_cr;
	comp_set_t  comps_s2;
	logic       hold;

	assign cfg_ready = 1'b1;
	assign accept    = pixel_valid && !pixel_stall;
	assign pixel_stall = hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= FMT_ARGB;
			matrix_select_q <= MAT_FULL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SOURCE_FORMAT: source_format_q <= cfg_data;
				REG_MATRIX_SELECT: matrix_select_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_comb begin
		pix1 = split_rgb(first_pixel, source_format_q);
		pix2 = split_rgb(second_pixel, source_format_q);
		k_y  = y_coef(matrix_select_q);
		k_cb = cb_coef(matrix_select_q);
		k_cr = cr_coef(matrix_select_q);
	end

	// Chroma comes from the first pixel only.
	r2v_lane u_lane_y1 (.clk(clk), .pix(pix1), .coef(k_y),  .comp_s2(comps_s2.y1));
	r2v_lane u_lane_cb (.clk(clk), .pix(pix1), .coef(k_cb), .comp_s2(comps_s2.cb));
	r2v_lane u_lane_cr (.clk(clk), .pix(pix1), .coef(k_cr), .comp_s2(comps_s2.cr));
	r2v_lane u_lane_y2 (.clk(clk), .pix(pix2), .coef(k_y),  .comp_s2(comps_s2.y2));

	r2v_pack #(
		.DEPTH(FIFO_DEPTH)
	) u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.comps_s2   (comps_s2),
		.hold       (hold),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.packed_word(packed_word),
		.last       (last)
	);

endmodule

// ----- hw/rtl/r2v_lane.sv -----
// One color-conversion lane: three products, sum, floor shift, offset, clamp.
// Two register stages. Depends on r2v_pkg.
`timescale 1ns / 1ps

module r2v_lane
	import r2v_pkg::*;
(
	input  logic              clk,
	input  rgb_t              pix,
	input  coef_t             coef,
	output logic [COMP_W-1:0] comp_s2
);

	logic signed [19:0] pr_s1;
	logic signed [19:0] pg_s1;
	logic signed [19:0] pb_s1;
	logic [9:0]         off_s1;

	logic signed [21:0] sum;
	logic signed [21:0] shifted;
	logic signed [12:0] biased;

	always_ff @(posedge clk) begin
		pr_s1  <= $signed({1'b0, pix.r}) * coef.kr;
		pg_s1  <= $signed({1'b0, pix.g}) * coef.kg;
		pb_s1  <= $signed({1'b0, pix.b}) * coef.kb;
		off_s1 <= coef.off;
	end

	always_comb begin
		sum     = 22'(pr_s1) + 22'(pg_s1) + 22'(pb_s1);
		shifted = sum >>> 8;
		biased  = shifted[12:0] + $signed({3'b000, off_s1});
	end

	always_ff @(posedge clk) begin
		if (biased < 0) begin
			comp_s2 <= '0;
		end else if (biased > 13'sd1023) begin
			comp_s2 <= '1;
		end else begin
			comp_s2 <= biased[COMP_W-1:0];
		end
	end

endmodule

// ----- hw/rtl/r2v_pack.sv -----
// v210 merge stage: phase counter, partial word and output word queue.
// Takes one component set per cycle and queues one or two words. Depends on r2v_pkg.
`timescale 1ns / 1ps

module r2v_pack
	import r2v_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s2,
	input  comp_set_t         comps_s2,
	output logic              hold,
	output logic              word_valid,
	input  logic              word_stall,
	output logic [WORD_W-1:0] packed_word,
	output logic              last
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;

	out_entry_t         mem [DEPTH];
	out_entry_t         head_q;
	logic               head_valid_q;
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   count_q;
	logic [1:0]         phase_q;
	logic [CARRY_W-1:0] carry_q;

	out_entry_t         e0;
	out_entry_t         e1;
	logic [1:0]         n_wr;
	logic [1:0]         phase_d;
	logic [CARRY_W-1:0] carry_d;
	logic               pop;
	logic               load;
	logic [PTR_W-1:0]   wr1;
	logic [PTR_W-1:0]   wr2;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		e0      = '{word: '0, last: 1'b1};
		e1      = '{word: '0, last: 1'b1};
		n_wr    = 2'd0;
		phase_d = phase_q;
		carry_d = carry_q;
		if (valid_s2) begin
			case (phase_q)
				PH_1: begin
					e0      = '{word: {comps_s2.y1, comps_s2.cb, carry_q[COMP_W-1:0]}, last: 1'b1};
					n_wr    = 2'd1;
					carry_d = {comps_s2.y2, comps_s2.cr};
					phase_d = PH_2;
				end
				PH_2: begin
					e0      = '{word: {comps_s2.cb, carry_q}, last: 1'b0};
					e1      = '{word: {comps_s2.y2, comps_s2.cr, comps_s2.y1}, last: 1'b1};
					n_wr    = 2'd2;
					carry_d = '0;
					phase_d = PH_0;
				end
				default: begin
					// The unreachable fourth phase code behaves as the first.
					e0      = '{word: {comps_s2.cr, comps_s2.y1, comps_s2.cb}, last: 1'b1};
					n_wr    = 2'd1;
					carry_d = {{COMP_W{1'b0}}, comps_s2.y2};
					phase_d = PH_1;
				end
			endcase
		end
	end

	assign wr1  = ptr_inc(wr_q);
	assign wr2  = ptr_inc(wr1);
	assign pop  = head_valid_q && !word_stall;
	// The queue head moves into the output register whenever that register frees up.
	assign load = (count_q != '0) && (!head_valid_q || pop);
	// Leave room for every word the lane stages may still deliver.
	assign hold = count_q > CNT_W'(DEPTH - WORDS_IN_FLIGHT);

	always_ff @(posedge clk) begin
		if (n_wr != 2'd0) begin
			mem[wr_q] <= e0;
		end
		if (n_wr == 2'd2) begin
			mem[wr1] <= e1;
		end
		if (load) begin
			head_q <= mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q         <= '0;
			rd_q         <= '0;
			count_q      <= '0;
			head_valid_q <= 1'b0;
			phase_q      <= PH_0;
			carry_q      <= '0;
		end else begin
			if (n_wr == 2'd2) begin
				wr_q <= wr2;
			end else if (n_wr == 2'd1) begin
				wr_q <= wr1;
			end
			if (load) begin
				rd_q <= ptr_inc(rd_q);
			end
			if (load) begin
				head_valid_q <= 1'b1;
			end else if (pop) begin
				head_valid_q <= 1'b0;
			end
			count_q <= count_q + CNT_W'(n_wr) - CNT_W'(load);
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

	assign word_valid  = head_valid_q;
	assign packed_word = head_q.word;
	assign last        = head_q.last;

endmodule

// ----- hw/rtl/r2v_checker.sv -----
// Port-level checker for rgb_to_v210_packer, bound to the top level below.
// Depends on rgb_to_v210_packer_macros.svh and the top-level port list.
`timescale 1ns / 1ps
`include "rgb_to_v210_packer_macros.svh"

module r2v_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pixel_valid,
	input logic        pixel_stall,
	input logic        word_valid,
	input logic        word_stall,
	input logic [29:0] packed_word,
	input logic        last
);

	// A stalled word transaction keeps its payload.
	`R2V_ASSERT_NEXT(a_word_hold, word_valid && word_stall, word_valid && $stable(packed_word) && $stable(last))

	// Every accepted pair has a word waiting once it has passed the lane stages, queue and output register.
	`R2V_ASSERT_IMPL(a_pair_latency, pixel_valid && !pixel_stall, ##4 word_valid)

	// The two words of one pair are queued together, so the mate follows at once.
	`R2V_ASSERT_NEXT(a_mate_ready, word_valid && !word_stall && !last, word_valid)

endmodule

bind rgb_to_v210_packer r2v_checker u_r2v_checker (.*);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the RGB to v210 packer: drives pixel pairs and register writes,
// predicts every packed word and compares it with the word port of the block.
// Depends on r2v_pkg and rgb_to_v210_packer.
`timescale 1ns / 1ps

module testbench
	import r2v_pkg::*;
();

	localparam logic [1:0] MAT_UNDEFINED = 2'd3;
	localparam int TIMEOUT_CYCLES = 500000;
	localparam int DRAIN_CYCLES   = 10;

	typedef enum logic [1:0] {PAIR_FIRST, PAIR_SECOND, PAIR_THIRD} pair_pos_t;
	typedef enum logic [1:0] {CH_Y, CH_CB, CH_CR} chan_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_BURSTY, STALL_HEAVY} stall_style_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              pixel_valid  = 1'b0;
	logic              pixel_stall;
	logic [31:0]       first_pixel  = '0;
	logic [31:0]       second_pixel = '0;
	logic              word_valid;
	logic              word_stall   = 1'b0;
	logic [WORD_W-1:0] packed_word;
	logic              last;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic              cfg_index    = REG_SOURCE_FORMAT;
	logic [1:0]        cfg_data     = '0;

	// Predicted state of the block.
	logic [1:0]   model_fmt = FMT_ARGB;
	logic [1:0]   model_mat = MAT_FULL;
	pair_pos_t    pair_pos  = PAIR_FIRST;
	logic [19:0]  carry     = '0;
	out_entry_t   pending_words[$];
	out_entry_t   oldest;

	int           mismatches  = 0;
	int           cycle_count = 0;
	int           burst_left  = 8;
	bit           gaps_on     = 1'b1;
	bit           pix_driving = 1'b0;
	stall_style_t stall_style = STALL_LIGHT;
	logic [4:0]   stall_tick  = '0;

	rgb_to_v210_packer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.first_pixel  (first_pixel),
		.second_pixel (second_pixel),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.packed_word  (packed_word),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic rgb_t byte_order(input logic [31:0] px, input logic [1:0] fmt);
		rgb_t c;
		case (fmt)
			FMT_ARGB: begin
				c = '{r: px[15:8], g: px[23:16], b: px[31:24]};
			end
			FMT_RGB24: begin
				c = '{r: px[7:0], g: px[15:8], b: px[23:16]};
			end
			FMT_BGRA, FMT_BGR24: begin
				c = '{r: px[23:16], g: px[15:8], b: px[7:0]};
			end
			default: begin
				c = '0;
			end
		endcase
		return c;
	endfunction

	// Weighted sum, floor division by 256, offset, then saturation to 10 bits.
	function automatic logic [9:0] convert(input logic [1:0] mat, input chan_t ch, input rgb_t c);
		int kr, kg, kb, off, acc;
		off = (ch == CH_Y) ? 64 : 512;
		case (mat)
			MAT_BT601: begin
				case (ch)
					CH_Y: begin kr = 263; kg = 516; kb = 100; end
					CH_CB: begin kr = -152; kg = -298; kb = 450; end
					default: begin kr = 450; kg = -377; kb = -73; end
				endcase
			end
			MAT_BT709: begin
				case (ch)
					CH_Y: begin kr = 187; kg = 629; kb = 63; end
					CH_CB: begin kr = -103; kg = -347; kb = 450; end
					default: begin kr = 450; kg = -409; kb = -41; end
				endcase
			end
			default: begin
				// The undefined preset code behaves as full range.
				case (ch)
					CH_Y: begin kr = 306; kg = 601; kb = 117; off = 0; end
					CH_CB: begin kr = -173; kg = -339; kb = 512; end
					default: begin kr = 512; kg = -429; kb = -83; end
				endcase
			end
		endcase
		acc = kr * int'(c.r) + kg * int'(c.g) + kb * int'(c.b);
		acc = (acc >>> 8) + off;
		if (acc < 0)
			return 10'd0;
		if (acc > 1023)
			return 10'h3FF;
		return acc[9:0];
	endfunction

	function automatic logic [31:0] argb(input logic [7:0] a, r, g, b);
		return {b, g, r, a};
	endfunction

	// The fourth byte is ignored in the 24-bit formats, so it gets random content.
	function automatic logic [31:0] rgb24(input logic [7:0] r, g, b);
		logic [7:0] spare;
		spare = 8'($urandom_range(0, 255));
		return {spare, b, g, r};
	endfunction

	function automatic logic [31:0] random_pixel();
		logic [31:0] px;
		px = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			for (int i = 0; i < 4; i++) begin
				if ($urandom_range(0, 1) == 1)
					px[8*i +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
			end
		end
		return px;
	endfunction

	task automatic push_word(input logic [WORD_W-1:0] w, input logic is_last);
		out_entry_t e;
		e.word = w;
		e.last = is_last;
		pending_words.push_back(e);
	endtask

	// Three pairs fill four v210 words: Cb Y0 Cr | Y1 Cb Y2 | Cr Y3 Cb | Y4 Cr Y5.
	task automatic predict_words(input logic [31:0] a, input logic [31:0] b);
		rgb_t p1, p2;
		logic [9:0] y1, y2, cb, cr;
		p1 = byte_order(a, model_fmt);
		p2 = byte_order(b, model_fmt);
		y1 = convert(model_mat, CH_Y, p1);
		cb = convert(model_mat, CH_CB, p1);
		cr = convert(model_mat, CH_CR, p1);
		y2 = convert(model_mat, CH_Y, p2);
		case (pair_pos)
			PAIR_SECOND: begin
				push_word({y1, cb, carry[9:0]}, 1'b1);
				carry = {y2, cr};
				pair_pos = PAIR_THIRD;
			end
			PAIR_THIRD: begin
				push_word({cb, carry}, 1'b0);
				push_word({y2, cr, y1}, 1'b1);
				carry = '0;
				pair_pos = PAIR_FIRST;
			end
			default: begin
				push_word({cr, y1, cb}, 1'b1);
				carry = {10'd0, y2};
				pair_pos = PAIR_SECOND;
			end
		endcase
	endtask

	// Valid stays high from one pair to the next inside a burst.
	task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
		pixel_valid <= 1'b1;
		first_pixel <= a;
		second_pixel <= b;
		pix_driving = 1'b1;
		do @(posedge clk); while (pixel_stall);
		predict_words(a, b);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on && $urandom_range(0, 3) != 0) begin
				pixel_valid <= 1'b0;
				pix_driving = 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		if (pix_driving) begin
			pixel_valid <= 1'b0;
			pix_driving = 1'b0;
		end
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_config(input logic [1:0] fmt, input logic [1:0] mat);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_SOURCE_FORMAT;
		cfg_data <= fmt;
		do @(posedge clk); while (!cfg_ready);
		model_fmt = fmt;
		cfg_index <= REG_MATRIX_SELECT;
		cfg_data <= mat;
		do @(posedge clk); while (!cfg_ready);
		model_mat = mat;
		cfg_valid <= 1'b0;
	endtask

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %h, actual %h", what, want, got);
	endtask

	// Runs on the register values left by reset.
	task automatic test_reset_values();
		send_pair(argb(8'($urandom_range(0, 255)), 8'h00, 8'h00, 8'h00),
			argb(8'($urandom_range(0, 255)), 8'hFF, 8'hFF, 8'hFF));
		send_pair(argb(8'hFF, 8'hFF, 8'h00, 8'h00), argb(8'h00, 8'h00, 8'hFF, 8'h00));
		send_pair(argb(8'h00, 8'h00, 8'h00, 8'hFF), argb(8'hFF, 8'hFF, 8'hFF, 8'h00));
	endtask

	task automatic test_byte_orders();
		for (int f = 0; f < 4; f++) begin
			set_config(2'(f), MAT_BT709);
			send_pair($urandom | 32'hFF00_0000, $urandom & 32'h00FF_FFFF);
			send_pair(32'h0080_FF10 | ($urandom & 32'hFF00_0000), 32'hFFFF_FFFF);
		end
	endtask

	// Blue drives Cb high and red drives Cr high; yellow and cyan are second pixels, so only their luma is used.
	task automatic test_presets();
		logic [1:0] mats[4];
		mats = '{MAT_FULL, MAT_BT601, MAT_BT709, MAT_UNDEFINED};
		for (int m = 0; m < 4; m++) begin
			set_config(FMT_RGB24, mats[m]);
			send_pair(rgb24(8'hFF, 8'hFF, 8'hFF), rgb24(8'h00, 8'h00, 8'h00));
			send_pair(rgb24(8'h00, 8'h00, 8'hFF), rgb24(8'hFF, 8'hFF, 8'h00));
			send_pair(rgb24(8'hFF, 8'h00, 8'h00), rgb24(8'h00, 8'hFF, 8'hFF));
		end
	endtask

	// The partial word from the old settings must survive a register change.
	task automatic test_split_group();
		set_config(FMT_BGRA, MAT_BT601);
		send_pair(random_pixel(), random_pixel());
		send_pair(random_pixel(), random_pixel());
		set_config(FMT_BGR24, MAT_FULL);
		send_pair(random_pixel(), random_pixel());
	endtask

	task automatic test_random_stream();
		int n;
		logic [1:0] fmt, mat;
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin fmt = FMT_ARGB; mat = MAT_FULL; end
				1: begin fmt = FMT_BGR24; mat = MAT_UNDEFINED; end
				default: begin
					fmt = 2'($urandom_range(0, 3));
					mat = 2'($urandom_range(0, 3));
				end
			endcase
			set_config(fmt, mat);
			stall_style = stall_style_t'(p % 4);
			gaps_on = (p % 3 != 0);
			n = $urandom_range(50, 90);
			repeat (n)
				send_pair(random_pixel(), random_pixel());
		end
	endtask

	always @(posedge clk) begin
		stall_tick <= stall_tick + 5'd1;
		case (stall_style)
			STALL_LIGHT: word_stall <= ($urandom_range(0, 99) < 30);
			STALL_BURSTY: word_stall <= (stall_tick < 5'd12);
			STALL_HEAVY: word_stall <= ($urandom_range(0, 99) < 70);
			default: word_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && word_valid && !word_stall) begin
			if (pending_words.size() == 0) begin
				report_mismatch("word with none pending", '0, packed_word);
			end else begin
				oldest = pending_words.pop_front();
				if (packed_word !== oldest.word)
					report_mismatch("packed_word", oldest.word, packed_word);
				if (last !== oldest.last)
					report_mismatch("last", WORD_W'(oldest.last), WORD_W'(last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TIMEOUT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_byte_orders();
		test_presets();
		test_split_group();
		test_random_stream();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_words.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/r2v_pkg.sv
hw/rtl/r2v_lane.sv
hw/rtl/r2v_pack.sv
hw/rtl/rgb_to_v210_packer.sv
hw/rtl/r2v_checker.sv
tb/sv/testbench.sv
